// File: rtl/hvd_pkg.sv
// Package for the HMM Viterbi decoder: sizes, action codes, cost arithmetic.
// No dependencies.
`default_nettype none
package hvd_pkg;

  localparam int MAX_STATES  = 8;
  localparam int NUM_SYMBOLS = 16;
  localparam int MAX_LEN     = 64;

  localparam int SW  = $clog2(MAX_STATES);
  localparam int NW  = $clog2(MAX_STATES + 1);
  localparam int YW  = $clog2(NUM_SYMBOLS);
  localparam int TW  = $clog2(MAX_LEN);
  localparam int CW  = 16;
  localparam int MW  = 24;

  localparam logic [MW-1:0] IMPOSSIBLE     = {MW{1'b1}};
  localparam logic [CW-1:0] COST_ZERO_PROB = {CW{1'b1}};
  localparam logic [TW-1:0] T_LAST         = TW'(MAX_LEN - 1);
  localparam logic [SW-1:0] S_MAX          = SW'(MAX_STATES - 1);

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_TRANS = 2'd1,
    ACT_EMIT  = 2'd2,
    ACT_OBS   = 2'd3
  } action_e;

  function automatic logic [MW-1:0] cost_add(input logic [MW-1:0] m, input logic [CW-1:0] c);
    logic [MW:0] sum;
    sum = {1'b0, m} + {{(MW+1-CW){1'b0}}, c};
    if (m == IMPOSSIBLE || c == COST_ZERO_PROB || sum >= {1'b0, IMPOSSIBLE}) begin
      return IMPOSSIBLE;
    end
    return sum[MW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/hmm_viterbi_decoder.sv
// Top level of the HMM Viterbi decoder: cost tables, path metric update,
// end-state search and backtrack. Depends on hvd_pkg.
// An observation runs add-compare-select over all MAX_STATES*MAX_STATES
// pairs of state and predecessor, one predecessor per cycle through the
// transition table memory, then pipeline drain and metric copy. A final
// observation adds an end-state search over the states in use, then a wait
// state for each backpointer memory read along the path, emitting from the
// last time step down to zero. Configuration is a single write-only
// register.
`default_nettype none
module hmm_viterbi_decoder (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [3:0]                cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [1:0]                action_i,
  input  wire logic [hvd_pkg::SW-1:0]    from_state_i,
  input  wire logic [hvd_pkg::SW-1:0]    to_state_i,
  input  wire logic [hvd_pkg::YW-1:0]    symbol_i,
  input  wire logic [hvd_pkg::CW-1:0]    cost_i,
  input  wire logic                      last_obs_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [hvd_pkg::SW-1:0]         path_state_o,
  output logic [hvd_pkg::TW-1:0]         time_step_o,
  output logic [hvd_pkg::MW-1:0]         path_cost_o,
  output logic                           last_o
);
  import hvd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACS, ST_DRAIN, ST_COPY, ST_ARG, ST_EMIT, ST_WAIT
  } state_e;

  state_e          state_q;
  logic [3:0]      cfg_q;
  logic [NW-1:0]   n_act;
  logic [TW-1:0]   t_q;
  logic [YW-1:0]   sym_q;
  logic            fin_obs_q;
  logic [SW-1:0]   s_q, j_q;
  logic            a1_valid_q;
  logic [SW-1:0]   a1_s_q, a1_j_q;
  logic [MW-1:0]   best_q;
  logic [SW-1:0]   bsel_q;
  logic [CW-1:0]   emit_q;
  logic            f_valid_q;
  logic [SW-1:0]   f_s_q, f_bp_q;
  logic [MW-1:0]   f_best_q;
  logic [CW-1:0]   f_emit_q;
  logic [MW-1:0]   pm_q  [MAX_STATES];
  logic [MW-1:0]   nxt_q [MAX_STATES];
  logic [SW-1:0]   cur_s_q;
  logic [TW-1:0]   step_q;
  logic [MW-1:0]   fcost_q;

  // memories
  logic [CW-1:0]   start_mem [MAX_STATES];
  logic [CW-1:0]   trans_mem [MAX_STATES*MAX_STATES];
  logic [CW-1:0]   emis_mem  [MAX_STATES*NUM_SYMBOLS];
  logic [SW-1:0]   bp_mem    [MAX_LEN*MAX_STATES];
  logic [CW-1:0]   start_rd_q, trans_rd_q, emis_rd_q;
  logic [SW-1:0]   bp_rd_q;

  logic            in_acc, out_acc, out_free;
  logic            bp_we, bp_re;
  logic [MW-1:0]   c_val, cand;
  logic [SW-1:0]   cand_j;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign out_free   = !out_valid_o || !out_stall_i;

  always_comb begin
    if (cfg_q == 4'd0) begin
      n_act = NW'(1);
    end else if ({{(NW > 4 ? NW-4 : 0){1'b0}}, cfg_q} > NW'(MAX_STATES)) begin
      n_act = NW'(MAX_STATES);
    end else begin
      n_act = NW'(cfg_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && action_e'(action_i) == ACT_START) begin
      start_mem[from_state_i] <= cost_i;
    end
    if (in_acc && action_e'(action_i) == ACT_TRANS) begin
      trans_mem[{from_state_i, to_state_i}] <= cost_i;
    end
    if (in_acc && action_e'(action_i) == ACT_EMIT) begin
      emis_mem[{from_state_i, symbol_i}] <= cost_i;
    end
    start_rd_q <= start_mem[s_q];
    trans_rd_q <= trans_mem[{j_q, s_q}];
    emis_rd_q  <= emis_mem[{s_q, sym_q}];
  end

  assign bp_we = f_valid_q;
  assign bp_re = (state_q == ST_EMIT) && out_free && (step_q != '0);

  always_ff @(posedge clk_i) begin
    if (bp_we) begin
      bp_mem[{t_q, f_s_q}] <= ({1'b0, f_s_q} < n_act) ? f_bp_q : '0;
    end
    if (bp_re) begin
      bp_rd_q <= bp_mem[{step_q, cur_s_q}];
    end
  end

  // add-compare-select on the data returned from the tables
  always_comb begin
    if (t_q == '0) begin
      c_val = cost_add('0, start_rd_q);
    end else begin
      c_val = cost_add(pm_q[a1_j_q], trans_rd_q);
    end
    cand   = best_q;
    cand_j = bsel_q;
    if (a1_j_q == '0) begin
      cand   = c_val;
      cand_j = '0;
    end else if (t_q != '0 && {1'b0, a1_j_q} < n_act && c_val < best_q) begin
      cand   = c_val;
      cand_j = a1_j_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= 4'd8;
      t_q         <= '0;
      s_q         <= '0;
      j_q         <= '0;
      a1_valid_q  <= 1'b0;
      f_valid_q   <= 1'b0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < MAX_STATES; i++) begin
        pm_q[i] <= IMPOSSIBLE;
      end
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (out_acc) begin
        out_valid_o <= 1'b0;
      end
      a1_valid_q <= (state_q == ST_ACS);
      a1_s_q     <= s_q;
      a1_j_q     <= j_q;
      f_valid_q  <= 1'b0;
      if (a1_valid_q) begin
        best_q <= cand;
        bsel_q <= cand_j;
        if (a1_j_q == '0) begin
          emit_q <= emis_rd_q;
        end
        if (a1_j_q == S_MAX) begin
          f_valid_q <= 1'b1;
          f_s_q     <= a1_s_q;
          f_best_q  <= cand;
          f_bp_q    <= cand_j;
          f_emit_q  <= (a1_j_q == '0) ? emis_rd_q : emit_q;
        end
      end
      if (f_valid_q) begin
        nxt_q[f_s_q] <= ({1'b0, f_s_q} < n_act) ? cost_add(f_best_q, f_emit_q) : IMPOSSIBLE;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && action_e'(action_i) == ACT_OBS) begin
            sym_q     <= symbol_i;
            fin_obs_q <= last_obs_i;
            s_q       <= '0;
            j_q       <= '0;
            state_q   <= ST_ACS;
          end
        end
        ST_ACS: begin
          j_q <= j_q + SW'(1);
          if (j_q == S_MAX) begin
            s_q <= s_q + SW'(1);
            if (s_q == S_MAX) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (!a1_valid_q && !f_valid_q) begin
            state_q <= ST_COPY;
          end
        end
        ST_COPY: begin
          for (int i = 0; i < MAX_STATES; i++) begin
            pm_q[i] <= nxt_q[i];
          end
          if (fin_obs_q || t_q == T_LAST) begin
            s_q     <= '0;
            state_q <= ST_ARG;
          end else begin
            t_q     <= t_q + TW'(1);
            state_q <= ST_IDLE;
          end
        end
        ST_ARG: begin
          if (s_q == '0 || pm_q[s_q] < fcost_q) begin
            fcost_q <= pm_q[s_q];
            cur_s_q <= s_q;
          end
          s_q <= s_q + SW'(1);
          if ({1'b0, s_q} == n_act - NW'(1)) begin
            step_q  <= t_q;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_o  <= 1'b1;
            path_state_o <= cur_s_q;
            time_step_o  <= step_q;
            path_cost_o  <= fcost_q;
            last_o       <= (step_q == '0);
            if (step_q == '0) begin
              t_q <= '0;
              for (int i = 0; i < MAX_STATES; i++) begin
                pm_q[i] <= IMPOSSIBLE;
              end
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_WAIT;
            end
          end
        end
        ST_WAIT: begin
          cur_s_q <= bp_rd_q;
          step_q  <= step_q - TW'(1);
          state_q <= ST_EMIT;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/hvd_checker.sv
// Port-level checker for hmm_viterbi_decoder, bound to the top level.
// Depends on hvd_pkg.
`default_nettype none
module hvd_checker (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic [hvd_pkg::SW-1:0] path_state_o,
  input wire logic [hvd_pkg::TW-1:0] time_step_o,
  input wire logic [hvd_pkg::MW-1:0] path_cost_o,
  input wire logic                   last_o
);
  import hvd_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(path_state_o)
      && $stable(time_step_o) && $stable(path_cost_o) && $stable(last_o))
    else $error("stalled result changed");

  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> time_step_o == '0)
    else $error("last flag away from step zero");

  a_step_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && time_step_o == '0 |-> last_o)
    else $error("step zero without last flag");

  a_cost_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o ##1 out_valid_o
      |-> path_cost_o == $past(path_cost_o) && time_step_o == $past(time_step_o) - TW'(1))
    else $error("path cost or step order broken within one backtrack");

endmodule

bind hmm_viterbi_decoder hvd_checker u_hvd_checker (.*);
`default_nettype wire

// File: bench/hmm_viterbi_decoder_test.sv
// Self-checking bench for hmm_viterbi_decoder: loads cost tables, decodes
// observation sequences, and checks every backtracked path step against an
// in-bench Viterbi predictor. Depends on hvd_pkg and the decoder RTL.
`timescale 1ns / 100ps
`default_nettype none
module hmm_viterbi_decoder_test;
  import hvd_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 430;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [SW-1:0] state;
    logic [TW-1:0] step;
    logic [MW-1:0] cost;
    logic          fin;
  } path_step_t;

  class viterbi_board;
    logic [CW-1:0] start_cost[MAX_STATES];
    logic [CW-1:0] trans_cost[MAX_STATES][MAX_STATES];
    logic [CW-1:0] emit_cost[MAX_STATES][NUM_SYMBOLS];
    logic [MW-1:0] metric[MAX_STATES];
    logic [SW-1:0] back_ptr[MAX_LEN][MAX_STATES];
    int            t_count;
    logic [3:0]    states_reg;
    path_step_t    path_q[$];
    int            errors;

    function new();
      foreach (metric[s]) metric[s] = IMPOSSIBLE;
      foreach (back_ptr[t, s]) back_ptr[t][s] = '0;
      t_count    = 0;
      states_reg = 4'd8;
      errors     = 0;
    endfunction

    function logic [MW-1:0] sat_add(logic [MW-1:0] m, logic [CW-1:0] c);
      logic [MW:0] sum;
      sum = {1'b0, m} + (MW + 1)'(c);
      if (m == IMPOSSIBLE || c == COST_ZERO_PROB || sum >= {1'b0, IMPOSSIBLE}) return IMPOSSIBLE;
      return sum[MW-1:0];
    endfunction

    function int active();
      if (states_reg == 0) return 1;
      if (states_reg > MAX_STATES) return MAX_STATES;
      return states_reg;
    endfunction

    function void take_request(action_e act, logic [SW-1:0] src, logic [SW-1:0] dst,
                               logic [YW-1:0] sym, logic [CW-1:0] c, logic fin_obs);
      logic [MW-1:0] nxt[MAX_STATES];
      logic [MW-1:0] base, cand, best_cost;
      logic [SW-1:0] bp;
      int n, t, best, cur;
      path_step_t ps;
      case (act)
        ACT_START: start_cost[src] = c;
        ACT_TRANS: trans_cost[src][dst] = c;
        ACT_EMIT:  emit_cost[src][sym] = c;
        default: begin
          n = active();
          t = (t_count >= MAX_LEN) ? MAX_LEN - 1 : t_count;
          for (int s = 0; s < MAX_STATES; s++) begin
            bp = '0;
            if (s >= n) begin
              nxt[s] = IMPOSSIBLE;
            end else begin
              if (t == 0) begin
                base = sat_add('0, start_cost[s]);
              end else begin
                base = IMPOSSIBLE;
                for (int j = 0; j < n; j++) begin
                  cand = sat_add(metric[j], trans_cost[j][s]);
                  if (j == 0 || cand < base) begin
                    base = cand;
                    bp = SW'(j);
                  end
                end
              end
              nxt[s] = sat_add(base, emit_cost[s][sym]);
            end
            back_ptr[t][s] = bp;
          end
          metric = nxt;
          if (!fin_obs && t < MAX_LEN - 1) begin
            t_count = t + 1;
          end else begin
            best = 0;
            best_cost = metric[0];
            for (int s = 1; s < n; s++) begin
              if (metric[s] < best_cost) begin
                best_cost = metric[s];
                best = s;
              end
            end
            cur = best;
            for (int k = t; k >= 0; k--) begin
              ps.state = SW'(cur);
              ps.step  = TW'(k);
              ps.cost  = best_cost;
              ps.fin   = (k == 0);
              path_q.push_back(ps);
              if (k > 0) cur = back_ptr[k][cur];
            end
            t_count = 0;
            foreach (metric[s]) metric[s] = IMPOSSIBLE;
          end
        end
      endcase
    endfunction

    function void check_path_step(path_step_t got);
      path_step_t want;
      if (path_q.size() == 0) begin
        $error("unexpected path step: state %0d step %0d", got.state, got.step);
        errors++;
        return;
      end
      want = path_q.pop_front();
      if (got.state !== want.state) begin
        $error("path_state: expected %0d, got %0d", want.state, got.state);
        errors++;
      end
      if (got.step !== want.step) begin
        $error("time_step: expected %0d, got %0d", want.step, got.step);
        errors++;
      end
      if (got.cost !== want.cost) begin
        $error("path_cost: expected %0h, got %0h", want.cost, got.cost);
        errors++;
      end
      if (got.fin !== want.fin) begin
        $error("last: expected %0b, got %0b", want.fin, got.fin);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [3:0]    cfg_wdata_i = '0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  logic [1:0]    action_i = '0;
  logic [SW-1:0] from_state_i = '0;
  logic [SW-1:0] to_state_i = '0;
  logic [YW-1:0] symbol_i = '0;
  logic [CW-1:0] cost_i = '0;
  logic          last_obs_i = 1'b0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic [SW-1:0] path_state_o;
  logic [TW-1:0] time_step_o;
  logic [MW-1:0] path_cost_o;
  logic          last_o;

  viterbi_board board = new();
  int  cycles = 0;
  int  items = 0;
  int  burst_left = 0;
  bit  hold_now = 1'b0;

  hmm_viterbi_decoder dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .action_i, .from_state_i, .to_state_i,
    .symbol_i, .cost_i, .last_obs_i,
    .out_valid_o, .out_stall_i, .path_state_o, .time_step_o, .path_cost_o, .last_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_path_step({path_state_o, time_step_o, path_cost_o, last_o});
    end
  end

  // receiver stall pattern, plus one long hold-off
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_now) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_now = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        0: out_stall_i = 1'b0;
        1: out_stall_i = ($urandom_range(0, 3) == 0);
        2: out_stall_i = ($urandom_range(0, 3) != 0);
        default: out_stall_i = ~out_stall_i;
      endcase
    end
  end

  function automatic logic [CW-1:0] pick_cost();
    case ($urandom_range(0, 7))
      0: return COST_ZERO_PROB;
      1: return '0;
      2: return CW'($urandom_range(0, 1023));
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic send(action_e act, logic [SW-1:0] src, logic [SW-1:0] dst,
                      logic [YW-1:0] sym, logic [CW-1:0] c, logic fin_obs);
    int gap;
    @(negedge clk_i);
    action_i     = act;
    from_state_i = src;
    to_state_i   = dst;
    symbol_i     = sym;
    cost_i       = c;
    last_obs_i   = fin_obs;
    in_valid_i   = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.take_request(act, src, dst, sym, c, fin_obs);
    items++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
    end else begin
      gap = 0;
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic set_states(logic [3:0] val);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (board.path_q.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    board.states_reg = val;
  endtask

  task automatic observe_seq(int len);
    for (int k = 0; k < len; k++) begin
      send(ACT_OBS, SW'($urandom), SW'($urandom), YW'($urandom), CW'($urandom),
           k == len - 1);
    end
  endtask

  task automatic random_loads(int num);
    action_e act;
    for (int k = 0; k < num; k++) begin
      act = action_e'($urandom_range(0, 2));
      send(act, SW'($urandom), SW'($urandom), YW'($urandom), pick_cost(), 1'b0);
    end
  endtask

  initial begin
    logic [3:0] cfg_vals[8] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd5, 4'd11, 4'd8};
    int phase;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill every table entry before any observation reads one
    for (int s = 0; s < MAX_STATES; s++) send(ACT_START, SW'(s), '0, '0, pick_cost(), 1'b0);
    for (int s = 0; s < MAX_STATES; s++)
      for (int d = 0; d < MAX_STATES; d++) send(ACT_TRANS, SW'(s), SW'(d), '0, pick_cost(), 1'b0);
    for (int s = 0; s < MAX_STATES; s++)
      for (int y = 0; y < NUM_SYMBOLS; y++)
        send(ACT_EMIT, SW'(s), '0, YW'(y), pick_cost(), 1'b0);

    // directed: single-step path, all starts impossible, all-zero ties, three-step path
    send(ACT_OBS, '0, '0, 4'hF, '0, 1'b1);
    for (int s = 0; s < MAX_STATES; s++) send(ACT_START, SW'(s), '0, '0, 16'hFFFF, 1'b0);
    observe_seq(2);
    for (int s = 0; s < MAX_STATES; s++) send(ACT_START, SW'(s), '0, '0, '0, 1'b0);
    send(ACT_EMIT, 3'd7, 3'd7, 4'hF, 16'hFFFE, 1'b0);
    send(ACT_TRANS, 3'd7, 3'd7, '0, 16'h0000, 1'b0);
    observe_seq(3);

    phase = 0;
    while (items < ITEM_TARGET) begin
      if (items > 300 && phase < 8) begin
        set_states(cfg_vals[phase]);
        phase++;
      end else if (items > 260 + 5 * phase && phase < 8 && phase % 2 == 1) begin
        set_states(cfg_vals[phase]);
        phase++;
      end else if (phase < 8 && items > 240 + 25 * phase) begin
        set_states(cfg_vals[phase]);
        phase++;
      end
      if (phase == 3 && !hold_now) hold_now = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2: random_loads($urandom_range(1, 4));
        3: begin
          for (int s = 0; s < MAX_STATES; s++)
            send(ACT_TRANS, 3'd0, SW'(s), '0, CW'(16'h0100), 1'b0);
        end
        4: observe_seq(($urandom_range(0, 3) == 0) ? 65 : $urandom_range(20, 40));
        default: observe_seq($urandom_range(1, 8));
      endcase
    end
    set_states(4'($urandom_range(1, 8)));

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (board.path_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
rtl/hvd_pkg.sv
rtl/hmm_viterbi_decoder.sv
rtl/hvd_checker.sv
bench/hmm_viterbi_decoder_test.sv
